// File: src/acmac_pkg.sv
package acmac_pkg;

   localparam int unsigned BlkW = 128;
   localparam int unsigned KeyW = 256;

   typedef enum logic [1:0] {
      FUNC_LOAD    = 2'd0,
      FUNC_ADVANCE = 2'd1,
      FUNC_MAC     = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CSR_KEY0 = 3'd0,
      CSR_KEY1 = 3'd1,
      CSR_KEY2 = 3'd2,
      CSR_KEY3 = 3'd3,
      CSR_MODE = 3'd4
   } csr_index_type;

   localparam logic [7:0] RbConst = 8'h87;

   typedef enum logic [1:0] {
      SRC_COUNTER = 2'd0,
      SRC_ZERO    = 2'd1,
      SRC_DATA    = 2'd2
   } src_type;

   typedef struct packed {
      logic    load_in;
      logic    load_ctr;
      logic    inc_ctr;
      logic    start;
      src_type src;
      logic    add_k1;
      logic    save_chain;
      logic    save_k1;
      logic    save_out;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic first;
      logic last;
      func_type func;
   } sts_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] r, b, p, aa, bb;
      logic [7:0] e;
      r = 8'd1;
      b = x;
      e = 8'd254;
      for (int k = 0; k < 8; k++) begin
         if (e[k]) begin
            p = 8'd0; aa = r; bb = b;
            for (int i = 0; i < 8; i++) begin
               if (bb[i]) p = p ^ aa;
               aa = xtime(aa);
            end
            r = p;
         end
         p = 8'd0; aa = b; bb = b;
         for (int i = 0; i < 8; i++) begin
            if (bb[i]) p = p ^ aa;
            aa = xtime(aa);
         end
         b = p;
      end
      return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]}
             ^ 8'h63;
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

endpackage

// File: src/acmac_aes.sv
module acmac_aes (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [acmac_pkg::BlkW-1:0] din,
   input  logic [acmac_pkg::KeyW-1:0] key,
   input  logic                      mode256,
   output logic [acmac_pkg::BlkW-1:0] dout,
   output logic                      done
);
   import acmac_pkg::*;

   logic [BlkW-1:0] st_ff, st_in;
   logic [KeyW-1:0] kw_ff, kw_in;
   logic [7:0]      rc_ff, rc_in;
   logic [3:0]      rnd_ff, rnd_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [3:0]      nr;
   logic [BlkW-1:0] sb, sr, mc, nx;
   logic [31:0]     w0, w1, w2, w3, t;
   logic [KeyW-1:0] kn;
   logic [7:0]      a0, a1, a2, a3, al;

   assign nr = mode256 ? 4'd14 : 4'd10;

   always_comb begin
      // Sliding key window: round key is the upper 128 bits; 256-bit mode
      // advances 128 bits per round, 128-bit mode advances a whole key.
      if (mode256) begin
         if (rnd_ff[0]) begin
            t = sub_word({kw_ff[23:0], kw_ff[31:24]}) ^ {rc_ff, 24'd0};
         end else begin
            t = sub_word(kw_ff[31:0]);
         end
         w0 = kw_ff[255:224] ^ t;
         w1 = kw_ff[223:192] ^ w0;
         w2 = kw_ff[191:160] ^ w1;
         w3 = kw_ff[159:128] ^ w2;
         kn = {kw_ff[127:0], w0, w1, w2, w3};
      end else begin
         t  = sub_word({kw_ff[151:128], kw_ff[159:152]}) ^ {rc_ff, 24'd0};
         w0 = kw_ff[255:224] ^ t;
         w1 = kw_ff[223:192] ^ w0;
         w2 = kw_ff[191:160] ^ w1;
         w3 = kw_ff[159:128] ^ w2;
         kn = {w0, w1, w2, w3, 128'd0};
      end
      for (int j = 0; j < 16; j++) sb[127-8*j -: 8] = sbox(st_ff[127-8*j -: 8]);
      for (int c = 0; c < 4; c++)
         for (int j = 0; j < 4; j++)
            sr[127-8*(j+4*c) -: 8] = sb[127-8*(j+4*((c+j)%4)) -: 8];
      for (int c = 0; c < 4; c++) begin
         a0 = sr[127-32*c -: 8]; a1 = sr[119-32*c -: 8];
         a2 = sr[111-32*c -: 8]; a3 = sr[103-32*c -: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         mc[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
         mc[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
         mc[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         mc[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      nx = ((rnd_ff == nr) ? sr : mc) ^ kn[255:128];
      st_in = st_ff; kw_in = kw_ff; rc_in = rc_ff; rnd_in = rnd_ff; busy_in = busy_ff;
      done_in = busy_ff && (rnd_ff == nr);
      if (start) begin
         st_in   = din ^ key[255:128];
         kw_in   = mode256 ? key : {key[255:128], 128'd0};
         if (!mode256) kw_in = {key[255:128], key[255:128]};
         rc_in   = 8'h01;
         rnd_in  = 4'd1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         st_in  = nx;
         kw_in  = kn;
         if (!mode256 || rnd_ff[0]) rc_in = xtime(rc_ff);
         rnd_in = rnd_ff + 4'd1;
         if (rnd_ff == nr) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in; kw_ff <= kw_in; rc_ff <= rc_in; rnd_ff <= rnd_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign dout = st_ff;
   assign done = done_ff;
endmodule

// File: src/acmac_datapath.sv
module acmac_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  acmac_pkg::cmd_type        cmd,
   output acmac_pkg::sts_type        sts,
   input  logic [260:0]              req_word,
   input  logic                      csr_we,
   input  logic [2:0]                csr_idx,
   input  logic [63:0]               csr_data,
   output logic [135:0]              rsp_word
);
   import acmac_pkg::*;

   logic [260:0]    rq_ff;
   logic [127:0]    ctr_ff, ch_ff, k1_ff, tg_ff;
   logic            chk_ff, mt_ff;
   logic [255:0]    key_ff;
   logic            md_ff;
   logic [127:0]    ain, aout, blk, ex;
   logic            adone;

   assign blk = rq_ff[131:4];
   assign ex  = rq_ff[260:133];

   always_comb begin
      case (cmd.src)
         SRC_COUNTER: ain = ctr_ff;
         SRC_ZERO:    ain = 128'd0;
         default:     ain = ch_ff ^ blk ^ (cmd.add_k1 ? k1_ff : 128'd0);
      endcase
   end

   acmac_aes u_aes (.clock, .reset, .start(cmd.start), .din(ain),
      .key(key_ff), .mode256(md_ff), .dout(aout), .done(adone));

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0; md_ff <= 1'b0; ctr_ff <= '0; ch_ff <= '0; k1_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_idx)
               CSR_KEY0: key_ff[255:192] <= csr_data;
               CSR_KEY1: key_ff[191:128] <= csr_data;
               CSR_KEY2: key_ff[127:64]  <= csr_data;
               CSR_KEY3: key_ff[63:0]    <= csr_data;
               CSR_MODE: md_ff           <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.load_ctr) ctr_ff <= blk;
         if (cmd.inc_ctr) ctr_ff <= ctr_ff + 128'd1;
         if (cmd.save_chain) ch_ff <= aout;
         if (cmd.save_k1) k1_ff <= {aout[126:0], 1'b0} ^ {120'd0, aout[127] ? RbConst : 8'h00};
      end
      if (cmd.load_in) rq_ff <= req_word;
      if (cmd.save_out) begin
         tg_ff  <= aout;
         chk_ff <= rq_ff[132];
         mt_ff  <= rq_ff[132] && (aout == ex);
      end
   end

   assign sts.done  = adone;
   assign sts.func  = func_type'(rq_ff[1:0]);
   assign sts.first = rq_ff[2];
   assign sts.last  = rq_ff[3];
   assign rsp_word  = {6'd0, mt_ff, chk_ff, tg_ff[63:0], tg_ff[127:64]};
endmodule

// File: src/acmac_ctrl.sv
module acmac_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  acmac_pkg::sts_type sts,
   output acmac_pkg::cmd_type cmd
);
   import acmac_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_DEC   = 7'b0000010,
      S_CTR   = 7'b0000100,
      S_ZERO  = 7'b0001000,
      S_BLK   = 7'b0010000,
      S_OUT   = 7'b0100000,
      S_START = 7'b1000000
   } state_type;

   state_type st_ff, st_in;
   logic      open_ff, open_in;

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = (st_ff == S_OUT);

   always_comb begin
      cmd = '0;
      cmd.src = SRC_DATA;
      st_in = st_ff;
      open_in = open_ff;
      case (st_ff)
         S_IDLE: if (req_tvalid) begin
            cmd.load_in = 1'b1;
            st_in = S_DEC;
         end
         S_DEC: begin
            st_in = S_IDLE;
            case (sts.func)
               FUNC_LOAD:    cmd.load_ctr = 1'b1;
               FUNC_ADVANCE: cmd.inc_ctr = 1'b1;
               FUNC_MAC: begin
                  if (sts.first || !open_ff) begin
                     cmd.src = SRC_COUNTER; cmd.start = 1'b1; st_in = S_CTR;
                  end else st_in = S_START;
               end
               default: ;
            endcase
         end
         S_CTR: if (sts.done) begin
            cmd.save_chain = 1'b1;
            cmd.src = SRC_ZERO; cmd.start = 1'b1; st_in = S_ZERO;
         end
         S_ZERO: if (sts.done) begin
            cmd.save_k1 = 1'b1; open_in = 1'b1; st_in = S_START;
         end
         S_START: begin
            cmd.add_k1 = sts.last; cmd.start = 1'b1; st_in = S_BLK;
         end
         S_BLK: if (sts.done) begin
            cmd.save_chain = 1'b1;
            if (sts.last) begin
               cmd.save_out = 1'b1; open_in = 1'b0; st_in = S_OUT;
            end else st_in = S_IDLE;
         end
         S_OUT: if (rsp_tready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; open_ff <= 1'b0;
      end else begin
         st_ff <= st_in; open_ff <= open_in;
      end
   end

`ifndef ASSERT_OFF
   a_one_src: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_ctr && cmd.inc_ctr)) else $error("counter load and advance together");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("response dropped");
   a_out_from_blk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(st_ff == S_BLK)) else $error("response without tag");
`endif
endmodule

// File: src/aes_cmac_counter_seeded.sv
// Channel  Ports           Payload
// req      req_t*          func, first_block, last_block, block, check_tag, expect
// rsp      rsp_t*          tag, checked, tag_match
// csr      csr_*           key words 0-3, key size mode
// Counter load or advance completes in the decode state. A continuing block takes one
// encryption (AES-128 or AES-256); a first block adds two more encryptions. The single
// AES core runs one round per cycle. Reset is synchronous and clears state and keys.
// A stalled response holds the block from taking the next request.
module aes_cmac_counter_seeded (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // func, first_block, last_block, block_hi, block_lo, check_tag, expect_hi, expect_lo
   input  logic [263:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tag_hi, tag_lo, checked, tag_match
   output logic [135:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_idx,
   input  logic [63:0]  csr_data
);
   import acmac_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [260:0] rw;

   // Blocks are big-endian 128-bit values with block_hi on top.
   assign rw = {req_tdata[196:133], req_tdata[260:197],
                req_tdata[132], req_tdata[67:4], req_tdata[131:68], req_tdata[3:0]};

   acmac_ctrl u_ctrl (.clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid,
      .rsp_tready, .sts, .cmd);

   acmac_datapath u_dp (.clock, .reset, .cmd, .sts, .req_word(rw), .csr_we,
      .csr_idx, .csr_data, .rsp_word(rsp_tdata));
endmodule
